FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define RTE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define RTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rte_pkg.sv
package rte_pkg;

    localparam int VAL_W       = 16;
    localparam int DIGITS      = 5;
    localparam int IDX_W       = 3;
    localparam int DIG_W       = 4;
    localparam int MAX_RUN_DEF = 65535;

    localparam logic [7:0] ESC_RESET = 8'h40;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGITS - 1);

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } in_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
    } out_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHAR   = 6'b000010,
        ST_REPEAT = 6'b000100,
        ST_ESC    = 6'b001000,
        ST_CALC   = 6'b010000,
        ST_DIGIT  = 6'b100000
    } state_t;

    function automatic logic [VAL_W-1:0] pow10(input logic [IDX_W-1:0] idx);
        logic [VAL_W-1:0] p;
        unique case (idx)
            3'd0:    p = VAL_W'(10000);
            3'd1:    p = VAL_W'(1000);
            3'd2:    p = VAL_W'(100);
            3'd3:    p = VAL_W'(10);
            default: p = VAL_W'(1);
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/rte_digit_unit.sv
module rte_digit_unit (
    input  logic [rte_pkg::VAL_W-1:0] val,
    input  logic [rte_pkg::IDX_W-1:0] pow_idx,
    output logic                      ge,
    output logic [rte_pkg::VAL_W-1:0] diff
);

    logic [rte_pkg::VAL_W-1:0] pw;

    // shared compare and subtract against the current power of ten
    always_comb begin
        pw   = rte_pkg::pow10(pow_idx);
        ge   = (val >= pw);
        diff = val - pw;
    end

endmodule

FILE: rtl/run_length_text_encoder.sv
// Run-length text encoder. Bytes arrive one item at a time on s_, the final
// byte of a string flagged by last_in; encoded bytes leave on m_, last_out on
// the final one. An item that extends or opens a run leaves s_ready high.
// An item that closes a run keeps s_ready low while the run is sent: the run
// byte, then a repeat byte or the escape byte and the count in decimal, with
// leading zeros of the count skipped and each digit found by compare-subtract
// steps in the single shared digit unit before it is sent. The escape byte
// (cfg_data, '@' after reset) is written on cfg_ and is always ready.
module run_length_text_encoder #(
    parameter int MAX_RUN = rte_pkg::MAX_RUN_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rte_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rte_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_data
);

    localparam int LEN_W = $clog2(MAX_RUN + 1);

    rte_pkg::state_t           state_reg, state_next;
    logic [7:0]                esc_reg;
    logic                      open_reg, open_next;
    logic [7:0]                rc_reg, rc_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [7:0]                em_char_reg, em_char_next;
    logic [LEN_W-1:0]          em_len_reg, em_len_next;
    logic                      em_last_reg, em_last_next;
    logic                      tail_reg, tail_next;
    logic [7:0]                tail_char_reg, tail_char_next;
    logic [rte_pkg::VAL_W-1:0] val_reg, val_next;
    logic [rte_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [rte_pkg::DIG_W-1:0] dig_reg, dig_next;
    logic                      started_reg, started_next;
    logic                      m_valid_reg, m_valid_next;
    rte_pkg::out_t             m_data_reg, m_data_next;

    logic                      out_free;
    logic                      job_done;
    logic                      cont;
    logic                      du_ge;
    logic [rte_pkg::VAL_W-1:0] du_diff;

    rte_digit_unit u_digit (
        .val     (val_reg),
        .pow_idx (idx_reg),
        .ge      (du_ge),
        .diff    (du_diff)
    );

    assign s_ready   = (state_reg == rte_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign cont      = open_reg && (s_data.char_in == rc_reg) &&
                       (len_reg < LEN_W'(MAX_RUN));

    always_comb begin
        state_next     = state_reg;
        open_next      = open_reg;
        rc_next        = rc_reg;
        len_next       = len_reg;
        em_char_next   = em_char_reg;
        em_len_next    = em_len_reg;
        em_last_next   = em_last_reg;
        tail_next      = tail_reg;
        tail_char_next = tail_char_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        dig_next       = dig_reg;
        started_next   = started_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        job_done       = 1'b0;

        unique case (state_reg)
            rte_pkg::ST_IDLE: begin
                if (s_valid) begin
                    priority if (cont) begin
                        if (s_data.last_in) begin
                            em_char_next = rc_reg;
                            em_len_next  = len_reg + LEN_W'(1);
                            em_last_next = 1'b1;
                            open_next    = 1'b0;
                            rc_next      = 8'd0;
                            len_next     = '0;
                            state_next   = rte_pkg::ST_CHAR;
                        end else begin
                            len_next = len_reg + LEN_W'(1);
                        end
                    end else if (open_reg) begin
                        em_char_next = rc_reg;
                        em_len_next  = len_reg;
                        em_last_next = 1'b0;
                        state_next   = rte_pkg::ST_CHAR;
                        if (s_data.last_in) begin
                            tail_next      = 1'b1;
                            tail_char_next = s_data.char_in;
                            open_next      = 1'b0;
                            rc_next        = 8'd0;
                            len_next       = '0;
                        end else begin
                            rc_next  = s_data.char_in;
                            len_next = LEN_W'(1);
                        end
                    end else if (s_data.last_in) begin
                        em_char_next = s_data.char_in;
                        em_len_next  = LEN_W'(1);
                        em_last_next = 1'b1;
                        state_next   = rte_pkg::ST_CHAR;
                    end else begin
                        open_next = 1'b1;
                        rc_next   = s_data.char_in;
                        len_next  = LEN_W'(1);
                    end
                end
            end
            rte_pkg::ST_CHAR: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.char_out = em_char_reg;
                    m_data_next.last_out = em_last_reg && (em_len_reg == LEN_W'(1));
                    priority if (em_len_reg == LEN_W'(1)) begin
                        job_done = 1'b1;
                    end else if (em_len_reg == LEN_W'(2)) begin
                        state_next = rte_pkg::ST_REPEAT;
                    end else begin
                        val_next   = rte_pkg::VAL_W'(em_len_reg) - rte_pkg::VAL_W'(3);
                        state_next = rte_pkg::ST_ESC;
                    end
                end
            end
            rte_pkg::ST_REPEAT: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.char_out = em_char_reg;
                    m_data_next.last_out = em_last_reg;
                    job_done             = 1'b1;
                end
            end
            rte_pkg::ST_ESC: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.char_out = esc_reg;
                    m_data_next.last_out = 1'b0;
                    idx_next             = '0;
                    dig_next             = '0;
                    started_next         = 1'b0;
                    state_next           = rte_pkg::ST_CALC;
                end
            end
            rte_pkg::ST_CALC: begin
                priority if (du_ge) begin
                    val_next = du_diff;
                    dig_next = dig_reg + rte_pkg::DIG_W'(1);
                end else if (dig_reg != '0 || started_reg || idx_reg == rte_pkg::IDX_LAST) begin
                    state_next = rte_pkg::ST_DIGIT;
                end else begin
                    // leading zero, skip it
                    idx_next = idx_reg + rte_pkg::IDX_W'(1);
                end
            end
            rte_pkg::ST_DIGIT: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.char_out = rte_pkg::CHAR_ZERO + 8'(dig_reg);
                    m_data_next.last_out = em_last_reg && (idx_reg == rte_pkg::IDX_LAST);
                    if (idx_reg == rte_pkg::IDX_LAST) begin
                        job_done = 1'b1;
                    end else begin
                        idx_next     = idx_reg + rte_pkg::IDX_W'(1);
                        dig_next     = '0;
                        started_next = 1'b1;
                        state_next   = rte_pkg::ST_CALC;
                    end
                end
            end
            default: begin
                state_next = rte_pkg::ST_IDLE;
            end
        endcase

        // after a finished run, send the one-byte run left by a closing item, else go idle
        if (job_done) begin
            if (tail_reg) begin
                em_char_next = tail_char_reg;
                em_len_next  = LEN_W'(1);
                em_last_next = 1'b1;
                tail_next    = 1'b0;
                state_next   = rte_pkg::ST_CHAR;
            end else begin
                state_next = rte_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rte_pkg::ST_IDLE;
            open_reg    <= 1'b0;
            rc_reg      <= 8'd0;
            len_reg     <= '0;
            tail_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            esc_reg     <= rte_pkg::ESC_RESET;
        end else begin
            state_reg   <= state_next;
            open_reg    <= open_next;
            rc_reg      <= rc_next;
            len_reg     <= len_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                esc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        em_char_reg   <= em_char_next;
        em_len_reg    <= em_len_next;
        em_last_reg   <= em_last_next;
        tail_char_reg <= tail_char_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        dig_reg       <= dig_next;
        started_reg   <= started_next;
        m_data_reg    <= m_data_next;
    end

endmodule

FILE: rtl/rte_checker.sv
`include "assert_macros.svh"

module rte_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input rte_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input rte_pkg::out_t m_data,
    input logic          cfg_valid,
    input logic          cfg_ready,
    input logic [7:0]    cfg_data
);

    // no item is offered straight out of reset
    `RTE_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // a closing item always yields output, so the input side goes busy
    `RTE_ASSERT(a_last_busy, aclk, aresetn, s_valid && s_ready && s_data.last_in |=> !s_ready, "ready after last item")

    `RTE_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result item dropped")

    `RTE_ASSERT(a_out_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_data), "stalled result changed")

endmodule

bind run_length_text_encoder rte_checker u_rte_checker (.*);

FILE: tb/run_length_text_encoder_test.sv
`timescale 1ns / 100ps

module run_length_text_encoder_test;

    localparam int RUN_LIMIT = rte_pkg::MAX_RUN_DEF;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    rte_pkg::in_t  s_data    = '0;
    logic          m_ready   = 1'b0;
    logic          cfg_valid = 1'b0;
    logic [7:0]    cfg_data  = '0;
    logic          s_ready;
    logic          m_valid;
    rte_pkg::out_t m_data;
    logic          cfg_ready;

    rte_pkg::in_t  byte_queue[$];
    rte_pkg::out_t encoded_expected[$];
    int            idle_pct       = 35;
    int            mismatch_count = 0;

    // encoder state as seen from outside
    logic [7:0]  esc_model   = rte_pkg::ESC_RESET;
    logic [7:0]  run_byte    = '0;
    int unsigned run_count   = 0;
    bit          run_pending = 1'b0;

    run_length_text_encoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    task automatic note_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // byte, then for longer runs a repeat or escape and decimal count
    function automatic void queue_run_bytes(input bit closes_string);
        logic [7:0]    burst[8];
        logic [7:0]    digits[5];
        int            n;
        int            nd;
        int unsigned   v;
        rte_pkg::out_t res;
        burst[0] = run_byte;
        n = 1;
        if (run_count == 2) begin
            burst[1] = run_byte;
            n = 2;
        end else if (run_count >= 3) begin
            burst[1] = esc_model;
            n = 2;
            v = run_count - 3;
            nd = 0;
            do begin
                digits[nd] = rte_pkg::CHAR_ZERO + 8'(v % 10);
                nd++;
                v = v / 10;
            end while (v != 0);
            while (nd > 0) begin
                nd--;
                burst[n] = digits[nd];
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            res.char_out = burst[i];
            res.last_out = closes_string && (i == n - 1);
            encoded_expected.push_back(res);
        end
    endfunction

    function automatic void encode_byte(input rte_pkg::in_t item);
        if (run_pending && item.char_in == run_byte && run_count < RUN_LIMIT) begin
            run_count++;
        end else begin
            if (run_pending)
                queue_run_bytes(1'b0);
            run_byte = item.char_in;
            run_count = 1;
            run_pending = 1'b1;
        end
        if (item.last_in) begin
            queue_run_bytes(1'b1);
            run_byte = '0;
            run_count = 0;
            run_pending = 1'b0;
        end
    endfunction

    task automatic push_run(input logic [7:0] c, input int len, input bit ends_string);
        rte_pkg::in_t item;
        for (int i = 0; i < len; i++) begin
            item.char_in = c;
            item.last_in = ends_string && (i == len - 1);
            byte_queue.push_back(item);
        end
    endtask

    function automatic int pick_run_length();
        int p;
        p = $urandom_range(99);
        if (p < 30)
            return 1;
        if (p < 50)
            return 2;
        if (p < 65)
            return 3;
        if (p < 85)
            return $urandom_range(12, 4);
        if (p < 95)
            return $urandom_range(40, 13);
        return $urandom_range(112, 100);
    endfunction

    task automatic random_strings(input int target);
        int         added;
        int         nruns;
        int         len;
        int         sel;
        logic [7:0] c;
        logic [7:0] prev;
        added = 0;
        prev = '0;
        while (added < target) begin
            nruns = $urandom_range(5, 1);
            for (int r = 0; r < nruns; r++) begin
                sel = $urandom_range(9);
                if (sel == 0)
                    c = esc_model;
                else if (sel == 1)
                    c = prev;
                else if (sel == 2)
                    c = rte_pkg::CHAR_ZERO + 8'($urandom_range(9));
                else
                    c = 8'($urandom_range(255));
                len = pick_run_length();
                push_run(c, len, r == nruns - 1);
                prev = c;
                added += len;
            end
        end
    endtask

    task automatic settle();
        while (byte_queue.size() != 0 || s_valid || encoded_expected.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_escape(input logic [7:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // item driver and ready pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= idle_pct);
            if (!s_valid || s_ready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= byte_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        rte_pkg::out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                esc_model = cfg_data;
            if (s_valid && s_ready)
                encode_byte(s_data);
            if (m_valid && m_ready) begin
                if (encoded_expected.size() == 0) begin
                    note_mismatch($sformatf("unexpected item char_out %02h last_out %0b",
                                            m_data.char_out, m_data.last_out));
                end else begin
                    want = encoded_expected.pop_front();
                    if (m_data.char_out !== want.char_out)
                        note_mismatch($sformatf("char_out %02h, expected %02h",
                                                m_data.char_out, want.char_out));
                    if (m_data.last_out !== want.last_out)
                        note_mismatch($sformatf("last_out %0b, expected %0b (char %02h)",
                                                m_data.last_out, want.last_out,
                                                want.char_out));
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single byte, pair, zero count, change at end, escape byte runs, two digits
        push_run(8'h00, 1, 1'b1);
        push_run(8'hFF, 2, 1'b1);
        push_run(8'h41, 3, 1'b1);
        push_run(8'h42, 4, 1'b0);
        push_run(8'h43, 1, 1'b1);
        push_run(rte_pkg::ESC_RESET, 3, 1'b1);
        push_run(rte_pkg::CHAR_ZERO, 13, 1'b1);
        settle();

        write_escape(8'h00);
        random_strings(125);
        settle();

        // no idling on either side
        write_escape(8'hFF);
        idle_pct = 0;
        random_strings(125);
        settle();
        idle_pct = 35;

        write_escape(8'($urandom_range(255)));
        random_strings(125);
        settle();

        write_escape(rte_pkg::CHAR_ZERO);
        random_strings(125);
        settle();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
